// ===== rtl/abpa_pkg.sv =====
// shared types, constants and the arctangent table of the phase angle block
package abpa_pkg;

	// defaults for the top level parameters
	localparam int COMPONENT_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF     = 12;

	// cordic work format: magnitudes normalized so the msb lands near bit 55
	localparam int WORK_NORM   = 56;
	localparam int WORK_W      = 58;
	localparam int CORDIC_STEPS = 30;

	// angle accumulator: 2^32 units per full turn
	localparam int ANGLE_W = 32;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = 32'h2000_0000;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// atan(2^-i) in turn units, rounded to nearest
	localparam logic [ANGLE_W-1:0] ATAN_LUT [0:CORDIC_STEPS-1] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
		32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
		32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
		32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
		32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
	};

	// how the vector was folded into the first octant
	typedef struct packed {
		logic alpha_neg;
		logic beta_neg;
		logic swapped;
		logic zero;
	} oct_flags_t;

	localparam int FLAGS_W = $bits(oct_flags_t);

endpackage

// ===== rtl/abpa_front.sv =====
// front end: folds an alpha/beta vector into the first octant
module abpa_front #(
	parameter int COMPONENT_BITS = abpa_pkg::COMPONENT_BITS_DEF
) (
	input  logic signed [COMPONENT_BITS-1:0] alpha_component,
	input  logic signed [COMPONENT_BITS-1:0] beta_component,
	output logic        [COMPONENT_BITS-1:0] large_mag,
	output logic        [COMPONENT_BITS-1:0] small_mag,
	output abpa_pkg::oct_flags_t             flags
);

	logic [COMPONENT_BITS-1:0] abs_a;
	logic [COMPONENT_BITS-1:0] abs_b;
	logic                      swap;

	// magnitude fits unsigned even for the most negative code
	always_comb begin
		abs_a = alpha_component[COMPONENT_BITS-1] ? COMPONENT_BITS'(-alpha_component)
			: COMPONENT_BITS'(alpha_component);
		abs_b = beta_component[COMPONENT_BITS-1] ? COMPONENT_BITS'(-beta_component)
			: COMPONENT_BITS'(beta_component);
		swap  = abs_b > abs_a;
		large_mag = swap ? abs_b : abs_a;
		small_mag = swap ? abs_a : abs_b;
		flags.alpha_neg = alpha_component[COMPONENT_BITS-1];
		flags.beta_neg  = beta_component[COMPONENT_BITS-1];
		flags.swapped   = swap;
		flags.zero      = (alpha_component == '0) && (beta_component == '0);
	end

endmodule

// ===== rtl/abpa_queue.sv =====
// small fifo between the fold front end and the cordic back end
module abpa_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] head_data
);

	localparam int DEPTH = abpa_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");

endmodule

// ===== rtl/abpa_cordic.sv =====
// back end: pipelined vectoring cordic, octant unfold and output register
module abpa_cordic #(
	parameter int COMPONENT_BITS = abpa_pkg::COMPONENT_BITS_DEF,
	parameter int ANGLE_BITS     = abpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  logic [COMPONENT_BITS-1:0] q_large,
	input  logic [COMPONENT_BITS-1:0] q_small,
	input  abpa_pkg::oct_flags_t      q_flags,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ANGLE_BITS-1:0]     angle,
	output logic                      zero
);

	localparam int STEPS      = abpa_pkg::CORDIC_STEPS;
	localparam int WW         = abpa_pkg::WORK_W;
	localparam int AW         = abpa_pkg::ANGLE_W;
	localparam int WORK_SHIFT = abpa_pkg::WORK_NORM - COMPONENT_BITS;

	logic                        en;
	logic                        v_s     [0:STEPS];
	logic signed [WW-1:0]        x_s     [0:STEPS];
	logic signed [WW-1:0]        y_s     [0:STEPS];
	logic signed [AW-1:0]        z_s     [0:STEPS];
	abpa_pkg::oct_flags_t        flags_s [0:STEPS];

	logic signed [AW-1:0]        z_clamp;
	logic        [AW-1:0]        t_oct;
	logic        [AW-1:0]        ang;
	logic                        out_valid_q;
	logic        [ANGLE_BITS-1:0] angle_q;
	logic                        zero_q;

	// whole pipe moves together; stalls only while the output is held
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				v_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= q_valid;
			for (int k = 0; k < STEPS; k++) begin
				v_s[k+1] <= v_s[k];
			end
			out_valid_q <= v_s[STEPS];
		end
	end

	// load stage: scale magnitudes into the work format
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]     <= WW'({q_large, {WORK_SHIFT{1'b0}}});
			y_s[0]     <= WW'({q_small, {WORK_SHIFT{1'b0}}});
			z_s[0]     <= '0;
			flags_s[0] <= q_flags;
		end
	end

	// one micro-rotation per stage, driving y toward zero
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [WW-1:0] xs;
		logic signed [WW-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				flags_s[i+1] <= flags_s[i];
				if (y_s[i] == '0) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (!y_s[i][WW-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + $signed(abpa_pkg::ATAN_LUT[i]);
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - $signed(abpa_pkg::ATAN_LUT[i]);
				end
			end
		end
	end

	// clamp to the octant, then undo the fold modulo one turn
	always_comb begin
		if (z_s[STEPS][AW-1]) begin
			z_clamp = '0;
		end else if (z_s[STEPS] > $signed(abpa_pkg::EIGHTH_TURN)) begin
			z_clamp = $signed(abpa_pkg::EIGHTH_TURN);
		end else begin
			z_clamp = z_s[STEPS];
		end
		t_oct = flags_s[STEPS].swapped ? abpa_pkg::QUARTER_TURN - AW'(z_clamp)
			: AW'(z_clamp);
		unique case ({flags_s[STEPS].alpha_neg, flags_s[STEPS].beta_neg})
			2'b00:   ang = t_oct;
			2'b10:   ang = abpa_pkg::HALF_TURN - t_oct;
			2'b11:   ang = abpa_pkg::HALF_TURN + t_oct;
			default: ang = '0 - t_oct;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= flags_s[STEPS].zero ? '0 : ang[AW-1 -: ANGLE_BITS];
			zero_q  <= flags_s[STEPS].zero;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign zero      = zero_q;

	a_stage_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s[0]) |=> v_s[1])
		else $error("cordic stage lost a request");

endmodule

// ===== rtl/alpha_beta_phase_angle.sv =====
// top level of the alpha/beta phase angle block: fold, queue, cordic back end
// path: queue, load stage, 30 cordic stages, output register; all hold while the output stalls
// throughput: one vector per cycle while the output is not stalled, through the 30-stage cordic pipeline
// a four-entry queue keeps accepting input while the output stalls, until it holds four entries
// reset: arst_n clears queue pointers, pipeline valid bits and the output valid; no clearing pass
module alpha_beta_phase_angle #(
	parameter int COMPONENT_BITS = abpa_pkg::COMPONENT_BITS_DEF,
	parameter int ANGLE_BITS     = abpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// input stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// alpha_component, beta_component (low bits first), zero padded to bytes
	input  logic [((2*COMPONENT_BITS+7)/8)*8-1:0]    s_tdata,
	// output stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// phase_angle, zero padded to bytes
	output logic [((ANGLE_BITS+7)/8)*8-1:0]          m_tdata,
	// zero_vector
	output logic                                     m_tuser
);

	localparam int OUT_DATA_W = ((ANGLE_BITS + 7) / 8) * 8;
	localparam int ENTRY_W    = 2 * COMPONENT_BITS + abpa_pkg::FLAGS_W;

	// unpacked input fields
	logic signed [COMPONENT_BITS-1:0] alpha_component;
	logic signed [COMPONENT_BITS-1:0] beta_component;

	// folded request from the front end
	logic [COMPONENT_BITS-1:0] fold_large;
	logic [COMPONENT_BITS-1:0] fold_small;
	abpa_pkg::oct_flags_t      fold_flags;

	// queue side signals
	logic                      q_full;
	logic                      q_push;
	logic                      q_valid;
	logic                      q_pop;
	logic [ENTRY_W-1:0]        q_head;
	logic [COMPONENT_BITS-1:0] q_large;
	logic [COMPONENT_BITS-1:0] q_small;
	abpa_pkg::oct_flags_t      q_flags;

	// back end result
	logic [ANGLE_BITS-1:0]     phase_angle;
	logic                      zero_vector;

	assign alpha_component = s_tdata[COMPONENT_BITS-1:0];
	assign beta_component  = s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS];

	// a request enters whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	abpa_front #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_front (
		.alpha_component(alpha_component),
		.beta_component (beta_component),
		.large_mag      (fold_large),
		.small_mag      (fold_small),
		.flags          (fold_flags)
	);

	abpa_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({fold_flags, fold_small, fold_large}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head_data(q_head)
	);

	// split the queue head back into its parts
	assign q_large = q_head[COMPONENT_BITS-1:0];
	assign q_small = q_head[2*COMPONENT_BITS-1:COMPONENT_BITS];
	assign q_flags = abpa_pkg::oct_flags_t'(q_head[ENTRY_W-1:2*COMPONENT_BITS]);

	abpa_cordic #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.ANGLE_BITS    (ANGLE_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_large  (q_large),
		.q_small  (q_small),
		.q_flags  (q_flags),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.angle    (phase_angle),
		.zero     (zero_vector)
	);

	assign m_tdata = OUT_DATA_W'(phase_angle);
	assign m_tuser = zero_vector;

	// a zero vector always reports angle zero
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (phase_angle == '0))
		else $error("zero vector with nonzero angle");

endmodule
